// ===== rtl/core/spq_pkg.sv =====
// Package for the stable priority process queue: field widths, operation and
// status codes, and the types shared by the sequencer, compare unit and top.
// No dependencies.
package spq_pkg;

	localparam int PID_W         = 4;
	localparam int PRIO_W        = 8;
	localparam int TOTAL_W       = 5;
	localparam int OP_W          = 2;
	localparam int STATUS_W      = 2;
	localparam int PID_SPACE     = 16;
	localparam int DEF_MAX_PROCS = 16;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_POP    = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;

	typedef struct packed {
		logic [PID_W-1:0]  pid;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [PID_W-1:0]  process_id;
		logic [PRIO_W-1:0] priority_req;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PID_W-1:0]    taken_id;
		logic [PRIO_W-1:0]   taken_priority;
		logic                head_valid;
		logic [PID_W-1:0]    head_id;
		logic [PRIO_W-1:0]   head_priority;
		logic [TOTAL_W-1:0]  entry_total;
	} result_t;

	typedef struct packed {
		logic match;
		logic lower;
	} cmp_t;

	typedef struct packed {
		logic idle;
		logic res_valid;
	} seq_stat_t;

endpackage

// ===== rtl/core/spq_slot_mem.sv =====
// Slot memory of the queue: one write port and one read port with a
// registered read. Depends on spq_pkg for the entry type.
module spq_slot_mem
	import spq_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_PROCS,
	parameter int AW    = $clog2(DEF_MAX_PROCS)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data
);

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/spq_cmp_unit.sv =====
// Shared compare unit: checks one slot against the request key for a process
// match and for a lower priority. Depends on spq_pkg.
module spq_cmp_unit
	import spq_pkg::*;
(
	input  entry_t            slot,
	input  logic [PID_W-1:0]  key_pid,
	input  logic [PRIO_W-1:0] key_prio,
	output cmp_t              cmp
);

	always_comb begin
		cmp.match = (slot.pid == key_pid);
		cmp.lower = (slot.prio < key_prio);
	end

endmodule

// ===== rtl/core/spq_seq.sv =====
// Sequencer of the queue: scans the slot memory one entry at a time through
// the shared compare unit, then shifts entries to open or close a gap.
// Depends on spq_pkg, spq_slot_mem and spq_cmp_unit.
module spq_seq
	import spq_pkg::*;
#(
	parameter int MAX_PROCS = DEF_MAX_PROCS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  req_t      req,
	input  logic      res_take,
	output seq_stat_t stat,
	output result_t   res
);

	localparam int AW = $clog2(MAX_PROCS);
	// More slots than process numbers can never fill, so the limit is capped.
	localparam logic [TOTAL_W-1:0] CAP =
		TOTAL_W'((MAX_PROCS < PID_SPACE) ? MAX_PROCS : PID_SPACE);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_INS_WR,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [TOTAL_W-1:0]  occ_q;
	logic [STATUS_W-1:0] status_q;
	logic [OP_W-1:0]     op_q;
	logic [PID_W-1:0]    pid_q;
	logic [PRIO_W-1:0]   prio_q;
	logic [TOTAL_W-1:0]  i_q;
	logic [TOTAL_W-1:0]  j_q;
	logic [TOTAL_W-1:0]  pos_q;
	logic [TOTAL_W-1:0]  fidx_q;
	logic                found_q;
	logic                pos_found_q;
	entry_t              hit_q;
	entry_t              taken_q;
	entry_t              head_q;

	logic          mem_wr_en;
	logic [AW-1:0] mem_wr_addr;
	entry_t        mem_wr_data;
	logic [AW-1:0] mem_rd_addr;
	entry_t        mem_rd_data;
	cmp_t          cmp;
	logic          is_ins;
	logic          hit;

	spq_slot_mem #(
		.DEPTH (MAX_PROCS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	spq_cmp_unit u_cmp (
		.slot     (mem_rd_data),
		.key_pid  (pid_q),
		.key_prio (prio_q),
		.cmp      (cmp)
	);

	assign is_ins = (op_q == OP_INSERT);
	// A pop always takes the head, whatever its process number.
	assign hit    = (op_q == OP_POP) ? (i_q == '0) : cmp.match;

	always_comb begin
		mem_rd_addr = AW'(i_q);
		mem_wr_en   = 1'b0;
		mem_wr_addr = AW'(j_q);
		mem_wr_data = mem_rd_data;
		unique case (state_q)
			S_SHIFT_RD: begin
				mem_rd_addr = is_ins ? AW'(j_q - 1'b1) : AW'(j_q + 1'b1);
			end
			S_SHIFT_WR: begin
				mem_wr_en = 1'b1;
			end
			S_INS_WR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = AW'(pos_q);
				mem_wr_data = '{pid: pid_q, prio: prio_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			occ_q    <= '0;
			status_q <= ST_DONE;
		end else begin
			// The head is mirrored so that it can be reported without a read.
			if (mem_wr_en && mem_wr_addr == '0) begin
				head_q <= mem_wr_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q        <= req.operation;
						pid_q       <= req.process_id;
						prio_q      <= req.priority_req;
						i_q         <= '0;
						found_q     <= 1'b0;
						pos_found_q <= 1'b0;
						status_q    <= ST_DONE;
						taken_q     <= '0;
						state_q     <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: begin
					if (i_q == occ_q) begin
						unique case (op_q) inside
							OP_INSERT: begin
								if (found_q) begin
									status_q <= ST_DUP;
									state_q  <= S_DONE;
								end else if (occ_q >= CAP) begin
									status_q <= ST_MISS;
									state_q  <= S_DONE;
								end else begin
									if (!pos_found_q) begin
										pos_q <= occ_q;
									end
									j_q     <= occ_q;
									state_q <= S_SHIFT_RD;
								end
							end
							OP_POP, OP_REMOVE: begin
								if (!found_q) begin
									status_q <= ST_MISS;
									state_q  <= S_DONE;
								end else begin
									j_q     <= fidx_q;
									state_q <= S_SHIFT_RD;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end else begin
						state_q <= S_SCAN_CMP;
					end
				end
				S_SCAN_CMP: begin
					if (hit && !found_q) begin
						found_q <= 1'b1;
						fidx_q  <= i_q;
						hit_q   <= mem_rd_data;
					end
					if (cmp.lower && !pos_found_q) begin
						pos_found_q <= 1'b1;
						pos_q       <= i_q;
					end
					i_q     <= i_q + 1'b1;
					state_q <= S_SCAN_RD;
				end
				S_SHIFT_RD: begin
					if (is_ins) begin
						state_q <= (j_q == pos_q) ? S_INS_WR : S_SHIFT_WR;
					end else if (j_q + 1'b1 >= occ_q) begin
						occ_q   <= occ_q - 1'b1;
						taken_q <= hit_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SHIFT_WR;
					end
				end
				S_SHIFT_WR: begin
					j_q     <= is_ins ? j_q - 1'b1 : j_q + 1'b1;
					state_q <= S_SHIFT_RD;
				end
				S_INS_WR: begin
					occ_q   <= occ_q + 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		stat.idle      = (state_q == S_IDLE);
		stat.res_valid = (state_q == S_DONE);

		res.status         = status_q;
		res.taken_id       = taken_q.pid;
		res.taken_priority = taken_q.prio;
		res.head_valid     = (occ_q != '0);
		res.head_id        = res.head_valid ? head_q.pid : '0;
		res.head_priority  = res.head_valid ? head_q.prio : '0;
		res.entry_total    = occ_q;
	end

endmodule

// ===== rtl/core/stable_priority_process_queue_top.sv =====
// Channel | Handshake            | Fields
// in      | in_valid, in_stall   | operation, process_id, priority_req
// out     | out_valid, out_stall | status, taken_id, taken_priority, head_*, entry_total
//
// Each of the N queued entries is read, then checked by the shared compare unit; M entries
// are then moved, each read and then written, through the slot memory; an insert ends by
// writing the new entry. in_stall is high from an input transfer until its result is loaded;
// a finished result waits only while the output register holds a stalled one. Reset returns
// the sequencer to idle and clears the count and the output valid flag, not the slot memory.
// Depends on spq_pkg and spq_seq.
module stable_priority_process_queue_top
	import spq_pkg::*;
#(
	parameter int MAX_PROCS = DEF_MAX_PROCS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OP_W-1:0]     operation,
	input  logic [PID_W-1:0]    process_id,
	input  logic [PRIO_W-1:0]   priority_req,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [PID_W-1:0]    taken_id,
	output logic [PRIO_W-1:0]   taken_priority,
	output logic                head_valid,
	output logic [PID_W-1:0]    head_id,
	output logic [PRIO_W-1:0]   head_priority,
	output logic [TOTAL_W-1:0]  entry_total
);

	seq_stat_t stat;
	result_t   res;
	result_t   res_q;
	req_t      req;
	logic      out_valid_q;
	logic      start;
	logic      res_take;

	assign req      = '{operation: operation, process_id: process_id,
	                    priority_req: priority_req};
	assign in_stall = !stat.idle;
	assign start    = in_valid && !in_stall;
	// The output register takes a result when empty or emptied in this cycle.
	assign res_take = stat.res_valid && (!out_valid_q || !out_stall);

	spq_seq #(
		.MAX_PROCS (MAX_PROCS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.res_take (res_take),
		.stat     (stat),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (res_take) begin
				out_valid_q <= 1'b1;
				res_q       <= res;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = res_q.status;
	assign taken_id       = res_q.taken_id;
	assign taken_priority = res_q.taken_priority;
	assign head_valid     = res_q.head_valid;
	assign head_id        = res_q.head_id;
	assign head_priority  = res_q.head_priority;
	assign entry_total    = res_q.entry_total;

`ifndef SYNTHESIS
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> in_stall)
		else $error("request transfer did not make the queue busy");

	a_head_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (head_valid == (entry_total != '0)))
		else $error("head valid disagrees with entry count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entry_total <= TOTAL_W'(PID_SPACE)))
		else $error("entry count exceeds number of process ids");

	a_dup_takes_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_DUP) |-> (taken_id == '0 && taken_priority == '0))
		else $error("duplicate insert reported a taken entry");
`endif

endmodule
